[hdl/atwf_pkg.sv]
// Package for the ADC temperature window filter.
// Shared widths, conversion constants, register indexes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package atwf_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int MV_W        = 12;
    localparam int TEMP_W      = 19;
    localparam int LIMIT_W     = 18;
    localparam int CFG_DATA_W  = 19;
    localparam int CFG_INDEX_W = 1;

    // Conversion: t0 = floor((9216*mv + NUM_BIAS) / 113) - Q_BIAS.
    // The divide is a multiply by RECIP = ceil(2^32/113) and a right shift by 32,
    // exact for every dividend below 2^25.
    localparam int NUM_W       = 25;
    localparam int QUO_W       = 18;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 32;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int DIV_CNT_W   = 1;

    localparam logic [NUM_W-1:0]     NUM_BIAS  = 25'd102;
    localparam logic [RECIP_W-1:0]   RECIP     = 26'd38008561;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 1'd1;

    localparam int TEMP_X_W = 21;
    localparam logic signed [TEMP_X_W-1:0] Q_BIAS   = 21'sd55628;
    localparam logic signed [TEMP_X_W-1:0] TEMP_MAX = 21'sd262143;
    localparam logic signed [TEMP_X_W-1:0] TEMP_MIN = -21'sd262144;

    localparam logic [LIMIT_W-1:0]            LIMIT_RESET  = 18'd1280;
    localparam logic signed [TEMP_W-1:0]      OFFSET_RESET = 19'sd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEVIATION_LIMIT = 1'b0,
        REG_AMBIENT_OFFSET  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic load;       // latch the incoming sample
        logic prep;       // build dividend, clear sum
        logic div_step;   // reciprocal multiply, take the quotient
        logic rd_en;      // read one window entry
        logic temp_en;    // form the saturated temperature
        logic commit;     // decide, write window, load output
    } atwf_cmd_t;

    typedef struct packed {
        logic window_full;
        logic out_free;
    } atwf_status_t;

endpackage

[hdl/adc_temperature_window_filter.sv]
// Top level of the ADC temperature window filter.
// Joins atwf_ctrl and atwf_datapath; uses atwf_pkg.
`timescale 1ns / 1ps

// Each item is a 10-bit ADC reading; it is converted to a temperature in signed
// fixed point with 8 fraction bits, minus ambient_offset, saturated to 19 bits.
// The first 2^WINDOW_LOG2 items fill the window and return result_valid = 0 with
// a zero temperature. After that every item returns the mean of the stored window
// (taken before the new sample is considered) and replaces the oldest entry only
// when its distance from the mean is strictly below deviation_limit. One item is
// in work at a time. Once the window is full, the time from accept to the next
// accept is set by summing the window one entry per cycle through the registered
// RAM read port; during the fill no entries are read. The conversion divide is a
// single reciprocal multiply that runs alongside the summing. A finished result
// waits in the output register while the next item is accepted; a result still
// held there by out_stall delays the commit of the following one. The user must
// write configuration only while idle; the block itself does not enforce it.

module adc_temperature_window_filter #(
    parameter int WINDOW_LOG2 = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [atwf_pkg::SAMPLE_W-1:0]       adc_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [atwf_pkg::TEMP_W-1:0]  filtered_temp,
    output logic                                result_valid,
    output logic                                sample_accepted,
    input  logic                                cfg_we,
    input  logic [atwf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [atwf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    atwf_pkg::atwf_cmd_t     cmd;
    atwf_pkg::atwf_status_t  status;
    logic [WINDOW_LOG2-1:0]  rd_addr;

    atwf_ctrl #(
        .WINDOW_LOG2 (WINDOW_LOG2)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    atwf_datapath #(
        .WINDOW_LOG2 (WINDOW_LOG2)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .rd_addr         (rd_addr),
        .adc_sample      (adc_sample),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .filtered_temp   (filtered_temp),
        .result_valid    (result_valid),
        .sample_accepted (sample_accepted)
    );

endmodule

[hdl/atwf_ram.sv]
// Generic simple dual-port RAM with registered read.
// Used for the sample window store. No dependencies.
`timescale 1ns / 1ps

module atwf_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/atwf_ctrl.sv]
// Controller for the ADC temperature window filter.
// Sequences sample load, divide, window summing and commit; uses atwf_pkg.
`timescale 1ns / 1ps

module atwf_ctrl #(
    parameter int WINDOW_LOG2 = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  atwf_pkg::atwf_status_t  status,
    output atwf_pkg::atwf_cmd_t     cmd,
    output logic [WINDOW_LOG2-1:0]  rd_addr
);

    localparam int DEPTH = 1 << WINDOW_LOG2;
    localparam int CNT_W = WINDOW_LOG2 + 1;
    localparam logic [CNT_W-1:0] RD_LAST = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] RD_DONE = CNT_W'(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CALC,
        S_TEMP,
        S_DECIDE
    } state_t;

    state_t                            state_reg, state_next;
    logic [atwf_pkg::DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]                  rd_cnt_reg, rd_cnt_next;
    logic                              div_done;
    logic                              sum_done;

    assign div_done = (div_cnt_reg == atwf_pkg::DIV_STEPS);
    assign sum_done = !status.window_full || (rd_cnt_reg == RD_DONE);
    assign in_stall = (state_reg != S_IDLE);
    assign rd_addr  = rd_cnt_reg[WINDOW_LOG2-1:0];

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        rd_cnt_next  = rd_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep     = 1'b1;
                div_cnt_next = '0;
                rd_cnt_next  = '0;
                state_next   = S_CALC;
            end
            S_CALC:
            begin
                // divider and window read run side by side
                if (!div_done)
                begin
                    cmd.div_step = 1'b1;
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
                if (status.window_full && !sum_done)
                begin
                    cmd.rd_en   = (rd_cnt_reg < RD_LAST);
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (div_done && sum_done)
                begin
                    state_next = S_TEMP;
                end
            end
            S_TEMP:
            begin
                cmd.temp_en = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
            rd_cnt_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            rd_cnt_reg  <= rd_cnt_next;
        end
    end

endmodule

[hdl/atwf_datapath.sv]
// Datapath for the ADC temperature window filter: conversion, reciprocal divide,
// window sum, outlier decision and output register. Uses atwf_pkg, atwf_ram.
`timescale 1ns / 1ps

module atwf_datapath #(
    parameter int WINDOW_LOG2 = 3
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  atwf_pkg::atwf_cmd_t                      cmd,
    output atwf_pkg::atwf_status_t                   status,
    input  logic [WINDOW_LOG2-1:0]                   rd_addr,
    input  logic [atwf_pkg::SAMPLE_W-1:0]            adc_sample,
    input  logic                                     cfg_we,
    input  logic [atwf_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [atwf_pkg::CFG_DATA_W-1:0]          cfg_data,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [atwf_pkg::TEMP_W-1:0]       filtered_temp,
    output logic                                     result_valid,
    output logic                                     sample_accepted
);

    localparam int DEPTH = 1 << WINDOW_LOG2;
    localparam int SUM_W = atwf_pkg::TEMP_W + WINDOW_LOG2;
    localparam int TW    = atwf_pkg::TEMP_W;
    localparam int XW    = atwf_pkg::TEMP_X_W;

    // configuration
    logic [atwf_pkg::LIMIT_W-1:0] limit_reg;
    logic signed [TW-1:0]         offset_reg;

    // conversion and divider
    logic [atwf_pkg::MV_W-1:0]    mv_reg;
    logic [atwf_pkg::MV_W:0]      s5;
    logic [atwf_pkg::NUM_W-1:0]   num_w;
    logic [atwf_pkg::NUM_W-1:0]   num_reg;
    logic [atwf_pkg::PROD_W-1:0]  prod_w;
    logic [atwf_pkg::QUO_W-1:0]   dq_reg;

    // temperature
    logic signed [XW-1:0]         temp_raw;
    logic signed [TW-1:0]         temp_reg;

    // window
    logic [WINDOW_LOG2-1:0]       wr_idx_reg;
    logic                         full_reg;
    logic [TW-1:0]                rd_data;
    logic                         acc_pending_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [SUM_W-1:0]      sum_shift;
    logic signed [TW-1:0]         mean_w;
    logic signed [TW:0]           diff_w;
    logic [TW:0]                  absdiff_w;
    logic                         accepted_w;
    logic                         ram_we;

    // output register
    logic                         out_valid_reg;
    logic signed [TW-1:0]         temp_out_reg;
    logic                         rvalid_out_reg;
    logic                         acc_out_reg;

    assign s5    = {3'b000, adc_sample} + {1'b0, adc_sample, 2'b00};
    // 9216*mv as (mv << 13) + (mv << 10)
    assign num_w = {mv_reg, 13'b0} + {3'b000, mv_reg, 10'b0} + atwf_pkg::NUM_BIAS;

    // quotient = (num * RECIP) >> 32
    assign prod_w = atwf_pkg::PROD_W'(num_reg) * atwf_pkg::PROD_W'(atwf_pkg::RECIP);

    assign temp_raw = $signed({{(XW - atwf_pkg::QUO_W){1'b0}}, dq_reg}) - atwf_pkg::Q_BIAS
                      - $signed({{(XW - TW){offset_reg[TW-1]}}, offset_reg});

    assign sum_shift  = sum_reg >>> WINDOW_LOG2;
    assign mean_w     = sum_shift[TW-1:0];
    assign diff_w     = {temp_reg[TW-1], temp_reg} - {mean_w[TW-1], mean_w};
    assign absdiff_w  = diff_w[TW] ? (~diff_w + 1'b1) : diff_w;
    assign accepted_w = !full_reg ||
                        (absdiff_w < {{(TW + 1 - atwf_pkg::LIMIT_W){1'b0}}, limit_reg});
    assign ram_we     = cmd.commit && accepted_w;

    assign status = '{window_full: full_reg, out_free: (!out_valid_reg || !out_stall)};

    atwf_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (temp_reg),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mv_reg <= s5[atwf_pkg::MV_W:1];
        end
        if (cmd.prep)
        begin
            num_reg <= num_w;
        end
        if (cmd.div_step)
        begin
            dq_reg <= prod_w[atwf_pkg::RECIP_SHIFT +: atwf_pkg::QUO_W];
        end
        if (cmd.prep)
        begin
            sum_reg <= '0;
        end
        else if (acc_pending_reg)
        begin
            sum_reg <= sum_reg + {{WINDOW_LOG2{rd_data[TW-1]}}, rd_data};
        end
        if (cmd.temp_en)
        begin
            if (temp_raw > atwf_pkg::TEMP_MAX)
            begin
                temp_reg <= atwf_pkg::TEMP_MAX[TW-1:0];
            end
            else if (temp_raw < atwf_pkg::TEMP_MIN)
            begin
                temp_reg <= atwf_pkg::TEMP_MIN[TW-1:0];
            end
            else
            begin
                temp_reg <= temp_raw[TW-1:0];
            end
        end
        if (cmd.commit)
        begin
            temp_out_reg   <= full_reg ? mean_w : '0;
            rvalid_out_reg <= full_reg;
            acc_out_reg    <= accepted_w;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg       <= atwf_pkg::LIMIT_RESET;
            offset_reg      <= atwf_pkg::OFFSET_RESET;
            wr_idx_reg      <= '0;
            full_reg        <= 1'b0;
            acc_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    atwf_pkg::REG_DEVIATION_LIMIT:
                    begin
                        limit_reg <= cfg_data[atwf_pkg::LIMIT_W-1:0];
                    end
                    atwf_pkg::REG_AMBIENT_OFFSET:
                    begin
                        offset_reg <= $signed(cfg_data[TW-1:0]);
                    end
                    default:
                    begin
                    end
                endcase
            end
            acc_pending_reg <= cmd.rd_en;
            if (ram_we)
            begin
                wr_idx_reg <= wr_idx_reg + 1'b1;
                if (!full_reg && (wr_idx_reg == {WINDOW_LOG2{1'b1}}))
                begin
                    full_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_temp   = temp_out_reg;
    assign result_valid    = rvalid_out_reg;
    assign sample_accepted = acc_out_reg;

    // every item is stored while the window fills
    a_fill_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !full_reg) |-> accepted_w)
        else $error("sample rejected during window fill");

    // once full, the window stays full
    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("window_full cleared without reset");

    // reciprocal quotient fits its register
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |->
            (prod_w[atwf_pkg::PROD_W-1:atwf_pkg::RECIP_SHIFT + atwf_pkg::QUO_W] == '0))
        else $error("divider quotient out of range");

    // a new result shows up only after a commit
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("output valid without commit");

endmodule
